// File: src/stepper_timed_move_sequencer_core_assert.svh
// Assertion macros for the timed stepper move sequencer.
// Relies on clk_i and rst_ni being visible where the macros are used.
`ifndef STEPPER_TIMED_MOVE_SEQUENCER_CORE_ASSERT_SVH
`define STEPPER_TIMED_MOVE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define STMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stms assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define STMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stms assertion failed");

`endif

// File: src/stms_pkg.sv
// Shared types and constants for the timed stepper move sequencer.
// No dependencies; used by the interfaces, the divider and the top level.
package stms_pkg;

  localparam int unsigned StepW   = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned MagW    = 15;
  localparam int unsigned DelayW  = 13;
  localparam int unsigned CoilW   = 4;
  localparam int unsigned NumPhase = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DelayW-1:0] TimeMin  = DelayW'(5);
  localparam logic [DelayW-1:0] TimeMax  = DelayW'(5000);
  localparam logic [DelayW-1:0] DelayMin = DelayW'(5);
  localparam logic [MagW-1:0]   MagMax   = MagW'(32767);

  // reset coil patterns per phase
  localparam logic [CoilW-1:0] PatReset0 = 4'b0101;
  localparam logic [CoilW-1:0] PatReset1 = 4'b0110;
  localparam logic [CoilW-1:0] PatReset2 = 4'b1010;
  localparam logic [CoilW-1:0] PatReset3 = 4'b1001;

  // request kinds
  localparam logic KindMove = 1'b0;
  localparam logic KindTick = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } stms_state_e;

endpackage

// File: src/stms_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on stms_pkg for field widths.
interface stms_in_if;
  import stms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [StepW-1:0] step_count;
  logic [TimeW-1:0]        move_time;

  modport source (output valid, kind, step_count, move_time, input ready);
  modport sink   (input valid, kind, step_count, move_time, output ready);
endinterface

interface stms_out_if;
  import stms_pkg::*;
  logic             valid;
  logic             ready;
  logic [CoilW-1:0] coil_bits;
  logic             busy_res;
  logic             stepped;
  logic             move_done;
  logic             rejected;

  modport source (output valid, coil_bits, busy_res, stepped, move_done, rejected,
                  input ready);
  modport sink   (input valid, coil_bits, busy_res, stepped, move_done, rejected,
                  output ready);
endinterface

// File: src/stms_divider.sv
// Restoring divider, one quotient bit per cycle, for the per-step delay.
// Depends on stms_pkg for widths.
module stms_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [stms_pkg::DelayW-1:0]   dividend_i,
  input  logic [stms_pkg::MagW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [stms_pkg::DelayW-1:0]   quot_o
);
  import stms_pkg::*;

  localparam int unsigned CntW = $clog2(DelayW);
  localparam logic [CntW-1:0] LastCnt = CntW'(DelayW - 1);

  logic [MagW-1:0]   rem_q, rem_d;
  logic [DelayW-1:0] quo_q, quo_d;
  logic [MagW-1:0]   dvs_q, dvs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [MagW:0]     part;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign part = {rem_q, quo_q[DelayW-1]};
  assign ge   = (part >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? MagW'(part - {1'b0, dvs_q}) : part[MagW-1:0];
      quo_d = {quo_q[DelayW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: src/stepper_timed_move_sequencer_core.sv
// Top level of the timed full-step stepper sequencer.
// Depends on stms_pkg, stms_in_if/stms_out_if, stms_divider and the assert header.
//
//   channel   dir   handshake          payload
//   in_i      in    valid/ready        kind, step_count, move_time
//   res_o     out   valid/ready        coil_bits, busy_res, stepped, move_done, rejected
//   cfg       in    cfg_we_i           cfg_idx_i, cfg_wdata_i (coil patterns)
//
// A tick, a rejected command or a zero-step command writes its result when it is accepted.
// A move command is accepted, runs one divider iteration per quotient bit, then writes its result.
// The divider's one-bit-per-cycle loop sets the length of a move command.
// Reset returns patterns to 5/6/10/9 and clears all motion state.
// A request is taken when idle and the result register is free or being drained.
module stepper_timed_move_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  stms_in_if.sink                       in_i,
  stms_out_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [stms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stms_pkg::CoilW-1:0]    cfg_wdata_i
);
  import stms_pkg::*;

  `include "stepper_timed_move_sequencer_core_assert.svh"

  stms_state_e       state_q, state_d;

  logic [CoilW-1:0]  pat_q [NumPhase];
  logic [MagW-1:0]   steps_q, steps_d;
  logic              rev_q, rev_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [DelayW-1:0] tick_q, tick_d;
  logic [1:0]        phase_q, phase_d;
  logic [CoilW-1:0]  coil_q, coil_d;
  logic              moving_q, moving_d;

  logic              ov_q, ov_d;
  logic              o_step_q, o_step_d;
  logic              o_done_q, o_done_d;
  logic              o_rej_q, o_rej_d;

  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [DelayW-1:0] div_quot;

  logic [StepW-1:0]  raw;
  logic [StepW-1:0]  mag16;
  logic [MagW-1:0]   mag;
  logic [DelayW-1:0] tim_c;
  logic [DelayW-1:0] tick_inc;
  logic [MagW-1:0]   steps_dec;

  assign in_i.ready = (state_q == ST_IDLE) && (!ov_q || res_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // step magnitude with saturation of the most negative count
  assign raw   = $unsigned(in_i.step_count);
  assign mag16 = raw[StepW-1] ? (StepW'(0) - raw) : raw;
  assign mag   = mag16[StepW-1] ? MagMax : mag16[MagW-1:0];

  // move time clamped to the legal window
  always_comb begin
    if (in_i.move_time < TimeW'(TimeMin)) begin
      tim_c = TimeMin;
    end else if (in_i.move_time > TimeW'(TimeMax)) begin
      tim_c = TimeMax;
    end else begin
      tim_c = in_i.move_time[DelayW-1:0];
    end
  end

  assign tick_inc  = tick_q + DelayW'(1);
  assign steps_dec = steps_q - MagW'(1);

  stms_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tim_c),
    .divisor_i  (mag),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer: next state, motion state and result register
  always_comb begin
    state_d   = state_q;
    steps_d   = steps_q;
    rev_d     = rev_q;
    delay_d   = delay_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    coil_d    = coil_q;
    moving_d  = moving_q;
    ov_d      = ov_q && !res_o.ready;
    o_step_d  = o_step_q;
    o_done_d  = o_done_q;
    o_rej_d   = o_rej_q;
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ov_d     = 1'b1;
          o_step_d = 1'b0;
          o_done_d = 1'b0;
          o_rej_d  = 1'b0;
          if (in_i.kind == KindMove) begin
            if (moving_q) begin
              o_rej_d = 1'b1;
            end else if (mag == '0) begin
              o_done_d = 1'b1;
            end else begin
              // result written once the divider finishes
              ov_d      = 1'b0;
              steps_d   = mag;
              rev_d     = raw[StepW-1];
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end else if (moving_q) begin
            tick_d = tick_inc;
            if (tick_inc >= delay_q) begin
              tick_d   = '0;
              phase_d  = rev_q ? (phase_q - 2'd1) : (phase_q + 2'd1);
              coil_d   = pat_q[phase_d];
              o_step_d = 1'b1;
              steps_d  = steps_dec;
              if (steps_dec == '0) begin
                moving_d = 1'b0;
                o_done_d = 1'b1;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          delay_d  = (div_quot < DelayMin) ? DelayMin : div_quot;
          tick_d   = '0;
          moving_d = 1'b1;
          ov_d     = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      steps_q  <= '0;
      rev_q    <= 1'b0;
      delay_q  <= DelayMin;
      tick_q   <= '0;
      phase_q  <= '0;
      coil_q   <= '0;
      moving_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      steps_q  <= steps_d;
      rev_q    <= rev_d;
      delay_q  <= delay_d;
      tick_q   <= tick_d;
      phase_q  <= phase_d;
      coil_q   <= coil_d;
      moving_q <= moving_d;
      ov_q     <= ov_d;
    end
  end

  // result flags, only read while valid
  always_ff @(posedge clk_i) begin
    o_step_q <= o_step_d;
    o_done_q <= o_done_d;
    o_rej_q  <= o_rej_d;
  end

  // coil pattern registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q[0] <= PatReset0;
      pat_q[1] <= PatReset1;
      pat_q[2] <= PatReset2;
      pat_q[3] <= PatReset3;
    end else if (cfg_we_i) begin
      pat_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign res_o.valid     = ov_q;
  assign res_o.coil_bits = coil_q;
  assign res_o.busy_res  = moving_q;
  assign res_o.stepped   = o_step_q;
  assign res_o.move_done = o_done_q;
  assign res_o.rejected  = o_rej_q;

  // checks
  `STMS_ASSERT_NOW(a_no_req_in_div, state_q == ST_DIV, !in_i.ready)
  `STMS_ASSERT_NOW(a_div_done_in_div, div_done, state_q == ST_DIV)
  `STMS_ASSERT_NOW(a_done_not_busy, ov_q && o_done_q, !moving_q)
  `STMS_ASSERT_NOW(a_reject_busy, ov_q && o_rej_q, moving_q)
  `STMS_ASSERT_NXT(a_div_leaves, state_q == ST_DIV && div_done, moving_q && ov_q)

endmodule
